### rtl/core/pic_pkg.sv
`default_nettype none

package pic_pkg;

  // Fixed field widths of the two channels
  localparam int OPCODE_W = 2;
  localparam int ADDR_W   = 26;
  localparam int DATA_W   = 32;
  localparam int RAISE_W  = 6;
  localparam int NOTIFY_W = 2;

  // Widest index fields over the supported configuration range
  localparam int ID_MAX_W   = 10;
  localparam int WORD_MAX_W = 5;
  localparam int CTX_MAX_W  = 4;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RAISE = 2'd2;

  // Address map region bases
  localparam logic [ADDR_W-1:0] PEND_BASE = 26'h000_1000;
  localparam logic [ADDR_W-1:0] ENAB_BASE = 26'h000_2000;
  localparam logic [ADDR_W-1:0] CTX_BASE  = 26'h020_0000;
  localparam logic [11:0]       OFF_THRESH = 12'h000;
  localparam logic [11:0]       OFF_CLAIM  = 12'h004;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [ADDR_W-1:0]   address;
    logic [DATA_W-1:0]   write_data;
    logic [RAISE_W-1:0]  raise_source;
  } pic_in_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic [NOTIFY_W-1:0] notify;
    logic                bad_access;
  } pic_out_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_PRIO,
    ACC_PEND,
    ACC_ENAB,
    ACC_THRESH,
    ACC_CLAIM,
    ACC_COMPLETE,
    ACC_RAISE
  } acc_kind_t;

  // Decoded transaction
  typedef struct packed {
    acc_kind_t             kind;
    logic                  wr;
    logic                  bad;
    logic [ID_MAX_W-1:0]   id;
    logic [WORD_MAX_W-1:0] word;
    logic [CTX_MAX_W-1:0]  ctx;
  } pic_access_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FINISH,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

### rtl/core/pic_decode.sv
`default_nettype none

module pic_decode #(
  parameter int NUM_SOURCES  = 64,
  parameter int NUM_CONTEXTS = 2
) (
  input  wire pic_pkg::pic_in_t din,
  output pic_pkg::pic_access_t  acc
);

  localparam int SRC_WORDS = (NUM_SOURCES + 31) / 32;

  logic [pic_pkg::ADDR_W-1:0] enab_off;
  logic [pic_pkg::ADDR_W-1:0] ctx_off;
  logic [18:0]                enab_ctx;
  logic [13:0]                thr_ctx;
  logic [9:0]                 low_idx;
  logic [11:0]                reg_off;

  // Split the address into region offsets
  assign enab_off = din.address - pic_pkg::ENAB_BASE;
  assign ctx_off  = din.address - pic_pkg::CTX_BASE;
  assign enab_ctx = enab_off[25:7];
  assign thr_ctx  = ctx_off[25:12];
  assign reg_off  = ctx_off[11:0];
  assign low_idx  = din.address[11:2];

  // Map opcode and address onto a register access
  always_comb begin
    acc      = '0;
    acc.kind = pic_pkg::ACC_NONE;
    case (din.opcode)
      pic_pkg::OP_RAISE: begin
        if (din.raise_source != '0 &&
            32'(din.raise_source) < 32'(NUM_SOURCES)) begin
          acc.kind = pic_pkg::ACC_RAISE;
          acc.id   = pic_pkg::ID_MAX_W'(din.raise_source);
        end
      end
      pic_pkg::OP_READ, pic_pkg::OP_WRITE: begin
        acc.wr = (din.opcode == pic_pkg::OP_WRITE);
        if (din.address[1:0] != 2'b00) begin
          acc.bad = 1'b1;
        end else if (din.address < pic_pkg::PEND_BASE) begin
          if (32'(low_idx) >= 32'(NUM_SOURCES)) begin
            acc.bad = 1'b1;
          end else if (low_idx != '0) begin
            acc.kind = pic_pkg::ACC_PRIO;
            acc.id   = low_idx;
          end
        end else if (din.address < pic_pkg::ENAB_BASE) begin
          if (32'(low_idx) >= 32'(SRC_WORDS)) begin
            acc.bad = 1'b1;
          end else if (!acc.wr) begin
            acc.kind = pic_pkg::ACC_PEND;
            acc.word = low_idx[4:0];
          end
        end else if (din.address < pic_pkg::CTX_BASE) begin
          if (32'(enab_ctx) >= 32'(NUM_CONTEXTS) ||
              32'(enab_off[6:2]) >= 32'(SRC_WORDS)) begin
            acc.bad = 1'b1;
          end else begin
            acc.kind = pic_pkg::ACC_ENAB;
            acc.word = enab_off[6:2];
            acc.ctx  = enab_ctx[3:0];
          end
        end else begin
          if (32'(thr_ctx) >= 32'(NUM_CONTEXTS) ||
              (reg_off != pic_pkg::OFF_THRESH && reg_off != pic_pkg::OFF_CLAIM)) begin
            acc.bad = 1'b1;
          end else begin
            acc.ctx = thr_ctx[3:0];
            if (reg_off == pic_pkg::OFF_THRESH) begin
              acc.kind = pic_pkg::ACC_THRESH;
            end else if (acc.wr) begin
              acc.kind = pic_pkg::ACC_COMPLETE;
            end else begin
              acc.kind = pic_pkg::ACC_CLAIM;
            end
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/platform_interrupt_controller.sv
// Platform interrupt controller in the standard RISC-V register layout. Each
// transaction is a bus read, a bus write or an interrupt raise and yields exactly
// one result carrying read data, a per-context notify bit and a bad-access flag.
// Source priorities live in a single-port-read RAM that a sequencer sweeps with
// one comparator lane per notify context plus the claim compare, so every
// transaction waits on the sweep over source ids 1..NUM_SOURCES-1 through the
// RAM read port, and a stalled output holds it further; the next transaction is
// taken in the cycle after its result is staged. After reset the priority RAM
// is cleared one entry per cycle while in_stall stays high.
`default_nettype none

module platform_interrupt_controller #(
  parameter int NUM_SOURCES  = 64,
  parameter int MAX_PRIORITY = 7,
  parameter int NUM_CONTEXTS = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pic_pkg::pic_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pic_pkg::pic_out_t      out_data
);

  localparam int ID_W      = $clog2(NUM_SOURCES);
  localparam int CNT_W     = ID_W + 1;
  localparam int PRIO_W    = $clog2(MAX_PRIORITY + 1);
  localparam int SRC_WORDS = (NUM_SOURCES + 31) / 32;
  localparam int PAD_W     = SRC_WORDS * 32;
  localparam int WORD_W    = (SRC_WORDS > 1) ? $clog2(SRC_WORDS) : 1;
  localparam int CTX_W     = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int LANES     = (NUM_CONTEXTS < 2) ? NUM_CONTEXTS : 2;

  pic_pkg::state_t      state_r, state_nxt;
  pic_pkg::pic_access_t acc_in;
  pic_pkg::pic_access_t acc_r;
  logic [31:0]          wdata_r;

  logic [CNT_W-1:0]       scan_id_r, scan_id_nxt;
  logic                   scan_vld_r, scan_vld_nxt;
  logic [ID_W-1:0]        rd_id_r;

  logic [NUM_SOURCES-1:0] pend_r, pend_nxt;
  logic [NUM_SOURCES-1:0] claimed_r, claimed_nxt;
  logic [NUM_SOURCES-1:0] en_r   [NUM_CONTEXTS];
  logic [NUM_SOURCES-1:0] en_nxt [NUM_CONTEXTS];
  logic [PRIO_W-1:0]      thr_r   [NUM_CONTEXTS];
  logic [PRIO_W-1:0]      thr_nxt [NUM_CONTEXTS];

  logic [ID_W-1:0]   best_r, best_nxt;
  logic [PRIO_W-1:0] best_prio_r, best_prio_nxt;
  logic [ID_W-1:0]   lane_first_r   [LANES];
  logic [ID_W-1:0]   lane_first_nxt [LANES];
  logic [1:0]        lane_hits_r    [LANES];
  logic [1:0]        lane_hits_nxt  [LANES];

  pic_pkg::pic_out_t res_r, res_nxt;
  pic_pkg::pic_out_t out_data_r;
  logic              out_valid_r;
  logic              out_load;

  logic [PRIO_W-1:0] prio_mem [NUM_SOURCES];
  logic [PRIO_W-1:0] prio_rdata_r;
  logic              mem_we;
  logic [ID_W-1:0]   mem_waddr;
  logic [PRIO_W-1:0] mem_wdata;
  logic [ID_W-1:0]   mem_raddr;

  logic [ID_W-1:0]              a_id;
  logic [WORD_W-1:0]            a_word;
  logic [CTX_W-1:0]             a_ctx;
  logic [ID_W-1:0]              cmp_id;
  logic                         cmp_ok;
  logic [PRIO_W-1:0]            wclamp;
  logic [SRC_WORDS-1:0][31:0]   pend_words;
  logic [SRC_WORDS-1:0][31:0]   en_words;
  logic                         avail;
  logic                         claim_hit;
  logic [LANES-1:0]             lane_hit;

  // Decode the incoming transaction
  pic_decode #(
    .NUM_SOURCES  (NUM_SOURCES),
    .NUM_CONTEXTS (NUM_CONTEXTS)
  ) u_decode (
    .din (in_data),
    .acc (acc_in)
  );

  assign in_stall  = (state_r != pic_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Narrow the decoded fields to this configuration
  assign a_id   = acc_r.id[ID_W-1:0];
  assign a_word = acc_r.word[WORD_W-1:0];
  assign a_ctx  = acc_r.ctx[CTX_W-1:0];
  assign cmp_id = wdata_r[ID_W-1:0];
  assign cmp_ok = (wdata_r != '0) && (wdata_r < 32'(NUM_SOURCES)) &&
                  claimed_r[cmp_id] && en_r[a_ctx][cmp_id];
  assign wclamp = (wdata_r > 32'(MAX_PRIORITY)) ? PRIO_W'(MAX_PRIORITY)
                                                : wdata_r[PRIO_W-1:0];
  assign pend_words = PAD_W'(pend_r);
  assign en_words   = PAD_W'(en_r[a_ctx]);

  // Compare one swept source against the claim best and each notify lane
  always_comb begin
    avail     = scan_vld_r && pend_r[rd_id_r] && !claimed_r[rd_id_r];
    claim_hit = avail && en_r[a_ctx][rd_id_r] && (prio_rdata_r > best_prio_r);
    for (int l = 0; l < LANES; l++) begin
      lane_hit[l] = avail && en_r[l][rd_id_r] && (prio_rdata_r > thr_r[l]);
    end
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    scan_id_nxt   = scan_id_r;
    scan_vld_nxt  = 1'b0;
    pend_nxt      = pend_r;
    claimed_nxt   = claimed_r;
    en_nxt        = en_r;
    thr_nxt       = thr_r;
    best_nxt      = best_r;
    best_prio_nxt = best_prio_r;
    lane_first_nxt = lane_first_r;
    lane_hits_nxt  = lane_hits_r;
    res_nxt       = res_r;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = a_id;
    mem_wdata     = wclamp;
    mem_raddr     = a_id;

    case (state_r)
      pic_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = scan_id_r[ID_W-1:0];
        mem_wdata = '0;
        if (scan_id_r == CNT_W'(NUM_SOURCES - 1)) begin
          state_nxt = pic_pkg::ST_IDLE;
        end else begin
          scan_id_nxt = scan_id_r + CNT_W'(1);
        end
      end

      pic_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = pic_pkg::ST_EXEC;
        end
      end

      pic_pkg::ST_EXEC: begin
        // Apply the register update and arm the sweep
        res_nxt            = '0;
        res_nxt.bad_access = acc_r.bad;
        best_nxt           = '0;
        best_prio_nxt      = thr_r[a_ctx];
        for (int l = 0; l < LANES; l++) begin
          lane_first_nxt[l] = '0;
          lane_hits_nxt[l]  = '0;
        end
        scan_id_nxt = CNT_W'(1);
        state_nxt   = pic_pkg::ST_SCAN;
        case (acc_r.kind)
          pic_pkg::ACC_PRIO: begin
            mem_we = acc_r.wr;
          end
          pic_pkg::ACC_PEND: begin
            res_nxt.read_data = pend_words[a_word];
          end
          pic_pkg::ACC_ENAB: begin
            if (acc_r.wr) begin
              for (int i = 0; i < NUM_SOURCES; i++) begin
                if (a_word == WORD_W'(i >> 5)) begin
                  en_nxt[a_ctx][i] = (i != 0) && wdata_r[i & 31];
                end
              end
            end else begin
              res_nxt.read_data = en_words[a_word];
            end
          end
          pic_pkg::ACC_THRESH: begin
            if (acc_r.wr) begin
              thr_nxt[a_ctx] = wclamp;
            end else begin
              res_nxt.read_data = 32'(thr_r[a_ctx]);
            end
          end
          pic_pkg::ACC_COMPLETE: begin
            if (cmp_ok) begin
              claimed_nxt[cmp_id] = 1'b0;
            end
          end
          pic_pkg::ACC_RAISE: begin
            if (!claimed_r[a_id]) begin
              pend_nxt[a_id] = 1'b1;
            end
          end
          default: ;
        endcase
      end

      pic_pkg::ST_SCAN: begin
        mem_raddr = scan_id_r[ID_W-1:0];
        // Priority read data arrives in the first sweep cycle
        if (scan_id_r == CNT_W'(1) && !scan_vld_r &&
            acc_r.kind == pic_pkg::ACC_PRIO && !acc_r.wr) begin
          res_nxt.read_data = 32'(prio_rdata_r);
        end
        if (scan_id_r < CNT_W'(NUM_SOURCES)) begin
          scan_vld_nxt = 1'b1;
          scan_id_nxt  = scan_id_r + CNT_W'(1);
        end
        // Track lowest hit and a second hit per notify lane
        for (int l = 0; l < LANES; l++) begin
          if (lane_hit[l]) begin
            if (lane_hits_r[l] == 2'd0) begin
              lane_first_nxt[l] = rd_id_r;
            end
            if (lane_hits_r[l] != 2'd2) begin
              lane_hits_nxt[l] = lane_hits_r[l] + 2'd1;
            end
          end
        end
        if (acc_r.kind == pic_pkg::ACC_CLAIM && claim_hit) begin
          best_nxt      = rd_id_r;
          best_prio_nxt = prio_rdata_r;
        end
        if (scan_id_r == CNT_W'(NUM_SOURCES) && !scan_vld_r) begin
          state_nxt = pic_pkg::ST_FINISH;
        end
      end

      pic_pkg::ST_FINISH: begin
        if (acc_r.kind == pic_pkg::ACC_CLAIM) begin
          res_nxt.read_data = 32'(best_r);
          if (best_r != '0) begin
            pend_nxt[best_r]    = 1'b0;
            claimed_nxt[best_r] = 1'b1;
          end
        end
        // A lane still notifies unless its only hit was just claimed
        for (int l = 0; l < LANES; l++) begin
          res_nxt.notify[l] = (lane_hits_r[l] == 2'd2) ||
                              (lane_hits_r[l] == 2'd1 && lane_first_r[l] != best_r);
        end
        state_nxt = pic_pkg::ST_OUT;
      end

      pic_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = pic_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pic_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pic_pkg::ST_CLEAR;
      scan_id_r  <= '0;
      scan_vld_r <= 1'b0;
      pend_r     <= '0;
      claimed_r  <= '0;
      for (int c = 0; c < NUM_CONTEXTS; c++) begin
        en_r[c]  <= '0;
        thr_r[c] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      scan_id_r  <= scan_id_nxt;
      scan_vld_r <= scan_vld_nxt;
      pend_r     <= pend_nxt;
      claimed_r  <= claimed_nxt;
      en_r       <= en_nxt;
      thr_r      <= thr_nxt;
    end
  end

  // Advance the payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      acc_r   <= acc_in;
      wdata_r <= in_data.write_data;
    end
    rd_id_r      <= scan_id_r[ID_W-1:0];
    best_r       <= best_nxt;
    best_prio_r  <= best_prio_nxt;
    lane_first_r <= lane_first_nxt;
    lane_hits_r  <= lane_hits_nxt;
    res_r        <= res_nxt;
  end

  // Priority RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      prio_mem[mem_waddr] <= mem_wdata;
    end
    prio_rdata_r <= prio_mem[mem_raddr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  // A claimed source never stays pending
  a_claimed_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r & claimed_r) == '0)
    else $error("source both pending and claimed");

  // Source zero stays inert
  a_source_zero_inert: assert property (@(posedge clk) disable iff (!rst_n)
    !pend_r[0] && !claimed_r[0])
    else $error("source zero became pending or claimed");

  // Sweep counter never exceeds NUM_SOURCES
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pic_pkg::ST_SCAN |-> scan_id_r <= CNT_W'(NUM_SOURCES))
    else $error("sweep ran past the last source");

  // A claimed winner beats the context threshold
  a_claim_above_thr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pic_pkg::ST_FINISH && acc_r.kind == pic_pkg::ACC_CLAIM && best_r != '0
    |-> best_prio_r > thr_r[a_ctx])
    else $error("claim winner not above threshold");

endmodule

`default_nettype wire
